FILE: rtl/gaussian_1d_mask_generator_defines.svh
// Assertion macros used by the Gaussian mask generator checker.
`ifndef GAUSSIAN_1D_MASK_GENERATOR_DEFINES_SVH
`define GAUSSIAN_1D_MASK_GENERATOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high
`define GM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gm check failed");

// Next-cycle implication, ignored while reset is high
`define GM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gm check failed");

// Next-cycle implication that also holds across reset
`define GM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("gm check failed");

`endif

FILE: rtl/gm_pkg.sv
// Shared types and constants of the Gaussian mask generator.
package gm_pkg;

   localparam int MAX_TAPS_DEFAULT = 64;

   localparam int SIGMA_W   = 15;
   localparam int TAPS_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_W     = 8;
   localparam int RSP_W     = 24;
   localparam int IDX_W     = 6;
   localparam int COEF_W    = 17;
   localparam int WEIGHT_W  = 17;
   localparam int SUM_W     = 23;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_CNT_W  = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS  = 1'b1;

   localparam logic [SIGMA_W-1:0] SIGMA_RESET = 15'd256;
   localparam logic [TAPS_W-1:0]  TAPS_RESET  = 7'd5;

   // Exp approximation constants
   localparam logic [32:0] Q32_ONE   = 33'h1_0000_0000;
   localparam logic [63:0] A_LIMIT   = 64'(32 * 65536);
   localparam logic [2:0]  EXP_TERMS = 3'd5;
   localparam logic [3:0]  SQUARINGS = 4'd8;
   localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

   // Reciprocals for exact 32-bit division by 3 (shift 33) and by 5 (shift 34)
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_ADIV, S_AWAIT, S_MUL, S_KDIV, S_KWAIT, S_SQR,
      S_RND, S_WRITE, S_SRD, S_SACC, S_NRD, S_NDIV, S_NWAIT, S_OUT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/gm_ram.sv
// Single-port synchronous RAM with registered read.
module gm_ram #(
   parameter int Width = 17,
   parameter int Depth = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
   input  logic [Width-1:0]                         wdata,
   output logic [Width-1:0]                         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/gm_div.sv
// Restoring divider, one quotient bit per cycle.
module gm_div (
   input  logic                clock,
   input  logic                reset,
   input  gm_pkg::div_req_type req,
   output gm_pkg::div_rsp_type rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [gm_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [gm_pkg::DIVISOR_W:0]        rem_ff, rem_in;
   logic [gm_pkg::DIVIDEND_W-1:0]     quo_ff, quo_in;
   logic [gm_pkg::DIVISOR_W-1:0]      dvs_ff, dvs_in;
   logic [gm_pkg::DIVISOR_W:0]        trial;

   // One shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff[gm_pkg::DIVISOR_W-1:0], quo_ff[gm_pkg::DIVIDEND_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[gm_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[gm_pkg::DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/gaussian_1d_mask_generator.sv
// Per tap: weighing takes one pass of the shared divider, five series steps (multiply,
// divide by k, subtract) and the repeated squarings; summing reads and adds the weight;
// normalizing takes one more divider pass. A setup state opens each request.
// One request at a time: the next is taken the cycle after the last tap leaves.
// Reset (synchronous) clears control state; the weight store needs no clear.
module gaussian_1d_mask_generator #(
   parameter int MaxTaps = gm_pkg::MAX_TAPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gm_pkg::REQ_W-1:0]      req_tdata,   // [0] start_req
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gm_pkg::RSP_W-1:0]      rsp_tdata,   // [5:0] tap_index, [22:6] coefficient
   output logic                          rsp_tlast,   // last_tap
   input  logic                          csr_we,
   input  logic [gm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gm_pkg::SIGMA_W-1:0]    csr_wdata
);

   localparam int AW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
   localparam int CW = $clog2(MaxTaps + 1);
   localparam int NW = (CW > gm_pkg::TAPS_W) ? CW : gm_pkg::TAPS_W;

   gm_pkg::state_type state_ff, state_in;

   logic [gm_pkg::SIGMA_W-1:0]  sigma_ff;
   logic [gm_pkg::TAPS_W-1:0]   taps_ff;
   logic [CW-1:0]               n_ff, n_in, i_ff, i_in, half, tap_off;
   logic [2*CW-1:0]             off_sq;
   logic [31:0]                 es_ff, es_in;
   logic [28:0]                 r_ff, r_in, p_ff, p_in;
   logic [28:0]                 kq_ff, kq_in, k_quo;
   logic [31:0]                 k_recip;
   logic [60:0]                 kq_prod;
   logic [32:0]                 h_ff, h_in;
   logic [2:0]                  k_ff, k_in;
   logic [3:0]                  sq_ff, sq_in;
   logic [63:0]                 sqp_ff, sqp_in;
   logic [gm_pkg::WEIGHT_W-1:0] w_ff, w_in;
   logic [gm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                        vld_ff, vld_in, last_ff, last_in;
   logic [gm_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [gm_pkg::COEF_W-1:0]   coef_ff, coef_in;
   logic [NW-1:0]               taps_ext;
   logic [CW-1:0]               n_req;
   logic [gm_pkg::SIGMA_W-1:0]  s_eff;
   logic [60:0]                 rh_prod;
   logic [33:0]                 w_round;
   logic [64:0]                 sq_round;
   logic                        at_last;

   gm_pkg::div_req_type         div_req;
   gm_pkg::div_rsp_type         div_rsp;

   logic                        ram_we;
   logic [AW-1:0]               ram_addr;
   logic [gm_pkg::WEIGHT_W-1:0] ram_rdata;

   gm_ram #(.Width(gm_pkg::WEIGHT_W), .Depth(MaxTaps)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (w_ff),
      .rdata (ram_rdata)
   );

   gm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= gm_pkg::SIGMA_RESET;
         taps_ff  <= gm_pkg::TAPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gm_pkg::CSR_SIGMA: sigma_ff <= csr_wdata;
            gm_pkg::CSR_TAPS:  taps_ff  <= csr_wdata[gm_pkg::TAPS_W-1:0];
            default: ;
         endcase
      end
   end

   // Helpers
   assign taps_ext = NW'(taps_ff);
   assign n_req    = (taps_ext > NW'(MaxTaps)) ? CW'(MaxTaps) : CW'(taps_ff);
   assign s_eff    = (sigma_ff == '0) ? gm_pkg::SIGMA_W'(1) : sigma_ff;
   assign half     = n_ff >> 1;
   assign tap_off  = (i_ff >= half) ? (i_ff - half) : (half - i_ff);
   assign off_sq   = tap_off * tap_off;
   assign rh_prod  = r_ff * h_ff[31:0];
   assign w_round  = 34'(h_ff) + 34'd32768;
   assign sq_round = 65'(sqp_ff) + 65'h8000_0000;
   assign at_last  = (i_ff == n_ff - CW'(1));

   // Series term divided by k (1..5): shifts or reciprocal multiplication
   assign k_recip  = (k_ff == 3'd3) ? gm_pkg::RECIP3 : gm_pkg::RECIP5;
   assign kq_prod  = p_ff * k_recip;

   always_comb begin
      unique case (k_ff)
         3'd2:    k_quo = p_ff >> 1;
         3'd3:    k_quo = 29'(kq_prod[60:33]);
         3'd4:    k_quo = p_ff >> 2;
         3'd5:    k_quo = 29'(kq_prod[60:34]);
         default: k_quo = p_ff;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      es_in    = es_ff;
      r_in     = r_ff;
      p_in     = p_ff;
      kq_in    = kq_ff;
      h_in     = h_ff;
      k_in     = k_ff;
      sq_in    = sq_ff;
      sqp_in   = sqp_ff;
      w_in     = w_ff;
      sum_in   = sum_ff;
      vld_in   = vld_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      coef_in  = coef_ff;
      req_tready       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      ram_we   = 1'b0;
      ram_addr = AW'(i_ff);
      unique case (state_ff)
         gm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tdata[0] && (n_req != '0)) begin
               n_in     = n_req;
               i_in     = '0;
               state_in = gm_pkg::S_SETUP;
            end
         end
         gm_pkg::S_SETUP: begin
            es_in    = {1'b0, 30'(s_eff) * 30'(s_eff), 1'b0};
            state_in = gm_pkg::S_ADIV;
         end
         gm_pkg::S_ADIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = (64'(off_sq) << 32) + 64'(es_ff >> 1);
            div_req.divisor  = es_ff;
            state_in = gm_pkg::S_AWAIT;
         end
         gm_pkg::S_AWAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= gm_pkg::A_LIMIT) begin
                  w_in     = '0;
                  state_in = gm_pkg::S_WRITE;
               end else begin
                  r_in     = {div_rsp.quotient[20:0], 8'b0};
                  h_in     = gm_pkg::Q32_ONE;
                  k_in     = gm_pkg::EXP_TERMS;
                  state_in = gm_pkg::S_MUL;
               end
            end
         end
         gm_pkg::S_MUL: begin
            p_in     = (h_ff == gm_pkg::Q32_ONE) ? r_ff : rh_prod[60:32];
            state_in = gm_pkg::S_KDIV;
         end
         gm_pkg::S_KDIV: begin
            kq_in    = k_quo;
            state_in = gm_pkg::S_KWAIT;
         end
         gm_pkg::S_KWAIT: begin
            h_in = gm_pkg::Q32_ONE - 33'(kq_ff);
            if (k_ff == 3'd1) begin
               sq_in    = '0;
               state_in = gm_pkg::S_SQR;
            end else begin
               k_in     = k_ff - 3'd1;
               state_in = gm_pkg::S_MUL;
            end
         end
         gm_pkg::S_SQR: begin
            if (sq_ff == gm_pkg::SQUARINGS) begin
               w_in     = w_round[32:16];
               state_in = gm_pkg::S_WRITE;
            end else if (h_ff < gm_pkg::Q32_ONE) begin
               sqp_in   = h_ff[31:0] * h_ff[31:0];
               state_in = gm_pkg::S_RND;
            end else begin
               sq_in = sq_ff + 4'd1;
            end
         end
         gm_pkg::S_RND: begin
            h_in     = sq_round[64:32];
            sq_in    = sq_ff + 4'd1;
            state_in = gm_pkg::S_SQR;
         end
         gm_pkg::S_WRITE: begin
            ram_we = 1'b1;
            if (at_last) begin
               i_in     = '0;
               sum_in   = '0;
               state_in = gm_pkg::S_SRD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = gm_pkg::S_ADIV;
            end
         end
         gm_pkg::S_SRD: begin
            state_in = gm_pkg::S_SACC;
         end
         gm_pkg::S_SACC: begin
            sum_in = sum_ff + gm_pkg::SUM_W'(ram_rdata);
            if (at_last) begin
               i_in     = '0;
               state_in = gm_pkg::S_NRD;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = gm_pkg::S_SRD;
            end
         end
         gm_pkg::S_NRD: begin
            state_in = gm_pkg::S_NDIV;
         end
         gm_pkg::S_NDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = 64'({ram_rdata, 16'b0}) + 64'(sum_ff >> 1);
            div_req.divisor  = 32'(sum_ff);
            state_in = gm_pkg::S_NWAIT;
         end
         gm_pkg::S_NWAIT: begin
            if (div_rsp.done) begin
               coef_in  = (div_rsp.quotient > 64'(gm_pkg::COEF_ONE)) ?
                          gm_pkg::COEF_ONE : div_rsp.quotient[gm_pkg::COEF_W-1:0];
               idx_in   = gm_pkg::IDX_W'(i_ff);
               last_in  = at_last;
               vld_in   = 1'b1;
               state_in = gm_pkg::S_OUT;
            end
         end
         gm_pkg::S_OUT: begin
            if (rsp_tready) begin
               vld_in = 1'b0;
               if (last_ff) begin
                  state_in = gm_pkg::S_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  state_in = gm_pkg::S_NRD;
               end
            end
         end
         default: state_in = gm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gm_pkg::S_IDLE;
         vld_ff   <= 1'b0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         i_ff     <= i_in;
      end
      n_ff    <= n_in;
      es_ff   <= es_in;
      r_ff    <= r_in;
      p_ff    <= p_in;
      kq_ff   <= kq_in;
      h_ff    <= h_in;
      k_ff    <= k_in;
      sq_ff   <= sq_in;
      sqp_ff  <= sqp_in;
      w_ff    <= w_in;
      sum_ff  <= sum_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
      coef_ff <= coef_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, coef_ff, idx_ff};
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/gm_checker.sv
// Port-level checks for the Gaussian mask generator, bound to the top level.
`include "gaussian_1d_mask_generator_defines.svh"

module gm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [gm_pkg::RSP_W-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   logic out_stall;

   assign out_stall = rsp_tvalid && !rsp_tready;

   // No new request taken while a tap is on offer
   `GM_ASSERT_IMPL(busy_while_out, clock, reset, rsp_tvalid, !req_tready)

   // Stalled tap holds
   `GM_ASSERT_NEXT(out_hold, clock, reset, out_stall, rsp_tvalid && $stable({rsp_tlast, rsp_tdata}))

   // Final tap ends the run
   `GM_ASSERT_NEXT(last_ends_run, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && req_tready)

   // Reset leaves no tap on offer
   `GM_ASSERT_NEXT_ALWAYS(reset_clears, clock, reset, !rsp_tvalid)

endmodule

bind gaussian_1d_mask_generator gm_checker u_gm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/sv/gaussian_1d_mask_generator_tb.sv
// Self-checking testbench for the normalized 1D Gaussian mask generator.
module gaussian_1d_mask_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_TAPS     = gm_pkg::MAX_TAPS_DEFAULT;
   localparam longint      CYCLE_LIMIT  = 20_000_000;
   localparam int          SETTLE_WAIT  = 200;
   localparam int          RANDOM_ITEMS = 215;
   localparam longint unsigned Q_ONE    = 64'h1_0000_0000;

   typedef struct {
      logic [gm_pkg::IDX_W-1:0]  tap_index;
      logic [gm_pkg::COEF_W-1:0] coefficient;
      logic                      last_tap;
   } tap_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [gm_pkg::REQ_W-1:0]     req_tdata = '0;     // [0] start_req
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [gm_pkg::RSP_W-1:0]     rsp_tdata;          // [5:0] tap_index, [22:6] coefficient
   logic                         rsp_tlast;          // last_tap
   logic                         csr_we = 1'b0;
   logic [gm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gm_pkg::SIGMA_W-1:0]   csr_wdata = '0;

   // predictor copy of the registers
   logic [gm_pkg::SIGMA_W-1:0]   sigma_reg = gm_pkg::SIGMA_RESET;
   logic [gm_pkg::TAPS_W-1:0]    taps_reg  = gm_pkg::TAPS_RESET;

   tap_result_type       expected_taps[$];
   int                   failures = 0;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   longint               cycle_count = 0;

   gaussian_1d_mask_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each accepted tap with the oldest expectation
   always @(posedge clock) begin
      tap_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_taps.size() == 0) begin
            $error("unexpected tap: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = expected_taps.pop_front();
            if (rsp_tdata[5:0] !== want.tap_index) begin
               $error("tap_index: expected %0d, actual %0d", want.tap_index,
                      rsp_tdata[5:0]);
               failures++;
            end
            if (rsp_tdata[22:6] !== want.coefficient) begin
               $error("coefficient: expected %0d, actual %0d", want.coefficient,
                      rsp_tdata[22:6]);
               failures++;
            end
            if (rsp_tlast !== want.last_tap) begin
               $error("last_tap: expected %0b, actual %0b", want.last_tap, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // exp(-a) for a in Q16.16, result Q1.16
   function automatic logic [gm_pkg::WEIGHT_W-1:0] gauss_weight(longint unsigned a);
      longint unsigned r, h;
      if (a >= 64'(32 * 65536))
         return '0;
      r = a << 8;
      h = Q_ONE;
      for (int k = 5; k >= 1; k--)
         h = Q_ONE - ((r * h) >> 32) / longint'(k);
      for (int k = 0; k < 8; k++)
         if (h < Q_ONE)
            h = (h * h + 64'h8000_0000) >> 32;
      return gm_pkg::WEIGHT_W'((h + 64'd32768) >> 16);
   endfunction

   // expected taps of one mask request
   task automatic predict_mask();
      int unsigned n, half, s;
      longint unsigned scale, d, a, c, total;
      longint unsigned weights[MAX_TAPS];
      tap_result_type t;
      n = taps_reg;
      if (n > MAX_TAPS)
         n = MAX_TAPS;
      s = (sigma_reg == 0) ? 1 : sigma_reg;
      scale = 2 * longint'(s) * longint'(s);
      half = n / 2;
      total = 0;
      for (int i = 0; i < n; i++) begin
         d = (i >= half) ? i - half : half - i;
         a = (((d * d) << 32) + scale / 2) / scale;
         weights[i] = gauss_weight(a);
         total += weights[i];
      end
      for (int i = 0; i < n; i++) begin
         c = (weights[i] * 65536 + total / 2) / total;
         if (c > 65536)
            c = 65536;
         t.tap_index   = gm_pkg::IDX_W'(i);
         t.coefficient = gm_pkg::COEF_W'(c);
         t.last_tap    = (i + 1 == n);
         expected_taps.push_back(t);
      end
   endtask

   // one request; valid stays up after acceptance unless a gap follows
   task automatic send_request(bit start);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(gm_pkg::REQ_W-1){1'b0}}, start};
      do @(posedge clock); while (!req_tready);
      if (start)
         predict_mask();
   endtask

   // drain all taps, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_taps.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable
   task automatic write_reg(logic [gm_pkg::CSR_IDX_W-1:0] idx,
                            logic [gm_pkg::SIGMA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == gm_pkg::CSR_SIGMA)
         sigma_reg = value;
      else
         taps_reg = value[gm_pkg::TAPS_W-1:0];
      @(posedge clock);
   endtask

   task automatic configure(int sigma, int taps);
      wait_idle();
      write_reg(gm_pkg::CSR_SIGMA, gm_pkg::SIGMA_W'(sigma));
      write_reg(gm_pkg::CSR_TAPS, gm_pkg::SIGMA_W'(taps));
      csr_we <= 1'b0;
   endtask

   // reset values, idle item, and a mask with the default setting
   task automatic test_defaults();
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
   endtask

   // zero taps, single tap, even asymmetric, full and saturated tap counts
   task automatic test_tap_limits();
      configure(256, 0);
      send_request(1'b1);
      configure(256, 1);
      send_request(1'b1);
      configure(384, 2);
      send_request(1'b1);
      configure(512, 6);
      send_request(1'b1);
      configure(1024, 64);
      send_request(1'b1);
      configure(2048, 65);
      send_request(1'b1);
      configure(32767, 127);
      send_request(1'b1);
   endtask

   // sigma zero, tiny sigma with vanishing tails, widest sigma
   task automatic test_sigma_limits();
      configure(0, 7);
      send_request(1'b1);
      configure(32, 33);
      send_request(1'b1);
      configure(16384, 9);
      send_request(1'b1);
      configure(32767, 4);
      send_request(1'b1);
      configure(1, 3);
      send_request(1'b1);
   endtask

   // random settings, each followed by a burst of requests
   task automatic test_random();
      int sent, sigma, taps, burst, pick;
      bit start;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // idling pattern by progress
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 27; recv_stall_pct = 50;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 50; recv_stall_pct = 27;
         end else begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
         pick = $urandom_range(99);
         sigma = (pick < 20) ? $urandom_range(0, 32767) : $urandom_range(32, 4096);
         pick = $urandom_range(99);
         if (pick < 2)
            taps = $urandom_range(0, 127);
         else if (pick < 12)
            taps = $urandom_range(0, 16);
         else
            taps = $urandom_range(1, 8);
         configure(sigma, taps);
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst; i++) begin
            start = ($urandom_range(99) < 90);
            send_request(start);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 27;
      recv_stall_pct = 50;
      test_defaults();
      test_tap_limits();
      test_sigma_limits();
      test_random();
      wait_idle();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
